// File: design/kit_pkg.sv
// Shared types, character codes and keyword tables for the keyword/identifier tokenizer.
`timescale 1ns / 1ps

package kit_pkg;

    // Default sizes handed to the top level
    localparam int POS_BITS_DEF    = 16;
    localparam int LEN_BITS_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed widths of the token fields
    localparam int TOK_POS_W = 16;
    localparam int TOK_LEN_W = 8;
    localparam int KW_COUNT  = 7;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    typedef enum logic [4:0] {
        KIND_LPAREN    = 5'd0,
        KIND_RPAREN    = 5'd1,
        KIND_COLON     = 5'd2,
        KIND_COMMA     = 5'd3,
        KIND_DOT       = 5'd4,
        KIND_DARROW    = 5'd5,
        KIND_PIPE      = 5'd6,
        KIND_EOF       = 5'd7,
        KIND_KW_FUN    = 5'd8,
        KIND_KW_FORALL = 5'd9,
        KIND_KW_TYPE   = 5'd10,
        KIND_KW_PROP   = 5'd11,
        KIND_KW_MATCH  = 5'd12,
        KIND_KW_WITH   = 5'd13,
        KIND_KW_END    = 5'd14,
        KIND_IDENT     = 5'd15,
        KIND_ERROR     = 5'd16
    } kit_kind_t;

    typedef struct packed {
        kit_kind_t             kind;
        logic [TOK_POS_W-1:0]  pos;
        logic [TOK_LEN_W-1:0]  len;
    } kit_token_t;

    // One queue entry: the tokens caused by one character
    typedef struct packed {
        logic       two;
        kit_token_t tok0;
        kit_token_t tok1;
    } kit_entry_t;

    // Keyword lengths: fun forall Type Prop match with end
    function automatic logic [2:0] kw_len(input int k);
        logic [2:0] r;
        case (k)
            0:       r = 3'd3;
            1:       r = 3'd6;
            2:       r = 3'd4;
            3:       r = 3'd4;
            4:       r = 3'd5;
            5:       r = 3'd4;
            6:       r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Keyword character k at index idx
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
        logic [47:0] txt;
        case (k)
            0:       txt = {"fun", 24'h0};
            1:       txt = "forall";
            2:       txt = {"Type", 16'h0};
            3:       txt = {"Prop", 16'h0};
            4:       txt = {"match", 8'h0};
            5:       txt = {"with", 16'h0};
            6:       txt = {"end", 24'h0};
            default: txt = 48'h0;
        endcase
        return (idx < 3'd6) ? txt[8*(3'd5 - idx) +: 8] : 8'h00;
    endfunction

    // Drop the keywords that no longer match at index idx
    function automatic logic [KW_COUNT-1:0] filter_cands(input logic [KW_COUNT-1:0] cand,
                                                         input logic [15:0] idx,
                                                         input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        r = cand;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (idx >= 16'(kw_len(k)) || kw_char(k, idx[2:0]) != c)
                r[k] = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: design/kit_front.sv
// Front end: takes one character a beat, tracks lexer state, builds token entries.
`timescale 1ns / 1ps

module kit_front
    import kit_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ch_valid,
    input  logic [7:0]  ch,
    input  logic        full,
    output logic        ch_stall,
    output logic        push,
    output kit_entry_t  push_entry
);

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic                id_reg, id_next;
    logic                eq_reg, eq_next;
    logic [KW_COUNT-1:0] cand_reg, cand_next;

    logic       accept;
    logic       ch_letter, ch_numeral, is_ws;
    logic       pre_v, own_v, skip_own, kw_found;
    kit_token_t pre_tok, own_tok;
    logic [TOK_LEN_W-1:0] id_len_out;

    assign ch_stall = full;
    assign accept   = ch_valid && !full;

    assign ch_letter  = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    assign ch_numeral = ch inside {[8'h30:8'h39]};
    assign is_ws      = ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};

    // Identifier length as reported, saturated to the field width
    assign id_len_out = (32'(len_reg) > 32'd255) ? 8'hFF : TOK_LEN_W'(len_reg);

    // Character classification and state update
    always_comb
    begin
        pos_next   = pos_reg + 1'b1;
        start_next = start_reg;
        len_next   = len_reg;
        id_next    = id_reg;
        eq_next    = 1'b0;
        cand_next  = cand_reg;
        pre_v      = 1'b0;
        own_v      = 1'b0;
        skip_own   = 1'b0;
        kw_found   = 1'b0;
        pre_tok    = '{kind: KIND_ERROR, pos: TOK_POS_W'(start_reg), len: 8'd1};
        own_tok    = '{kind: KIND_ERROR, pos: TOK_POS_W'(pos_reg), len: 8'd1};

        // Pending '=' resolves first
        if (eq_reg)
        begin
            if (ch == CH_GT)
            begin
                pre_v       = 1'b1;
                pre_tok.kind = KIND_DARROW;
                pre_tok.len  = 8'd2;
                skip_own     = 1'b1;
            end
            else
            begin
                pre_v = 1'b1;
            end
        end

        // Open identifier: extend or close
        if (id_reg)
        begin
            if (ch_letter || ch_numeral)
            begin
                cand_next = filter_cands(cand_reg, 16'(len_reg), ch);
                if (len_reg != {LEN_BITS{1'b1}})
                    len_next = len_reg + 1'b1;
                skip_own = 1'b1;
            end
            else
            begin
                pre_v        = 1'b1;
                id_next      = 1'b0;
                pre_tok.kind = KIND_IDENT;
                pre_tok.len  = id_len_out;
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (!kw_found && cand_reg[k] && 16'(len_reg) == 16'(kw_len(k)))
                    begin
                        kw_found     = 1'b1;
                        pre_tok.kind = kit_kind_t'(5'(int'(KIND_KW_FUN) + k));
                        pre_tok.len  = 8'(kw_len(k));
                    end
                end
            end
        end

        // The character's own token
        if (!skip_own)
        begin
            case (ch)
                CH_LPAREN: begin own_v = 1'b1; own_tok.kind = KIND_LPAREN; end
                CH_RPAREN: begin own_v = 1'b1; own_tok.kind = KIND_RPAREN; end
                CH_COLON:  begin own_v = 1'b1; own_tok.kind = KIND_COLON;  end
                CH_COMMA:  begin own_v = 1'b1; own_tok.kind = KIND_COMMA;  end
                CH_DOT:    begin own_v = 1'b1; own_tok.kind = KIND_DOT;    end
                CH_PIPE:   begin own_v = 1'b1; own_tok.kind = KIND_PIPE;   end
                CH_EQUALS:
                begin
                    eq_next    = 1'b1;
                    start_next = pos_reg;
                end
                CH_NUL:
                begin
                    own_v        = 1'b1;
                    own_tok.kind = KIND_EOF;
                    pos_next     = '0;
                end
                default:
                begin
                    if (ch_letter || ch == CH_UNDER)
                    begin
                        id_next    = 1'b1;
                        start_next = pos_reg;
                        len_next   = LEN_BITS'(1);
                        cand_next  = filter_cands({KW_COUNT{1'b1}}, 16'd0, ch);
                    end
                    else if (!is_ws)
                    begin
                        own_v = 1'b1;
                    end
                end
            endcase
        end

        // Pack into one entry, first token in tok0
        push            = accept && (pre_v || own_v);
        push_entry.two  = pre_v && own_v;
        push_entry.tok0 = pre_v ? pre_tok : own_tok;
        push_entry.tok1 = own_tok;
    end

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            id_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            cand_reg  <= {KW_COUNT{1'b1}};
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            eq_reg    <= eq_next;
            cand_reg  <= cand_next;
        end
    end

    // A pending '=' and an open identifier never coexist
    a_eq_id_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(eq_reg && id_reg))
        else $error("pending equals with open identifier");

    // A two-token entry always leads with a closed token from an earlier character
    a_two_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_entry.two) |-> (push_entry.tok0.pos == TOK_POS_W'(start_reg)))
        else $error("two-token entry does not lead with pending token");

endmodule

// File: design/kit_queue.sv
// Short entry queue between the front and the back end.
`timescale 1ns / 1ps

module kit_queue
    import kit_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  kit_entry_t  push_entry,
    input  logic        pop,
    output logic        full,
    output logic        head_valid,
    output kit_entry_t  head_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    kit_entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_reg, wr_next;
    logic [PTR_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue underflow");

endmodule

// File: design/kit_back.sv
// Back end: splits queue entries into single token beats through an output register.
`timescale 1ns / 1ps

module kit_back
    import kit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  kit_entry_t            head_entry,
    output logic                  pop,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output logic [4:0]            token_kind,
    output logic [TOK_POS_W-1:0]  token_pos,
    output logic [TOK_LEN_W-1:0]  token_len,
    output logic                  last
);

    logic       valid_reg, valid_next;
    logic       sub_reg, sub_next;
    kit_token_t tok_reg;
    logic       last_reg;
    logic       load, sel_last;
    kit_token_t sel_tok;

    assign sel_tok  = sub_reg ? head_entry.tok1 : head_entry.tok0;
    assign sel_last = !head_entry.two || sub_reg;
    assign load     = head_valid && (!valid_reg || !tok_stall);
    assign pop      = load && sel_last;

    // Output valid and second-token index
    always_comb
    begin
        valid_next = valid_reg && tok_stall;
        sub_next   = sub_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = !sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= sel_tok;
            last_reg <= sel_last;
        end
    end

    assign tok_valid  = valid_reg;
    assign token_kind = tok_reg.kind;
    assign token_pos  = tok_reg.pos;
    assign token_len  = tok_reg.len;
    assign last       = last_reg;

    // The second token is only pending while its two-token entry sits at the head
    a_sub_head: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (head_valid && head_entry.two))
        else $error("second-token index without a two-token head");

endmodule

// File: design/keyword_identifier_tokenizer_top.sv
// Top level of the keyword/identifier tokenizer.
//
// Input channel ch_valid/ch_stall/ch carries one source byte a beat. Output
// channel tok_valid/tok_stall carries one token a beat: token_kind,
// token_pos, token_len and last, which marks the final token caused by one
// byte. A byte gives zero, one or two tokens.
// Each token passes through the QUEUE_DEPTH-entry queue and then the output
// register. Bytes are taken at one a cycle while the queue is not full;
// tokens leave at one a cycle while tok_stall is low, so the input keeps full
// rate while the token count stays at or below one per byte; bytes that give
// two tokens are absorbed by the queue between front and back end.
// Reset clears position, lexer state, the queue and the output register;
// the first token position is 0. While tok_stall is high the output beat
// holds, the queue fills, and ch_stall rises once the queue is full.
`timescale 1ns / 1ps

module keyword_identifier_tokenizer_top
    import kit_pkg::*;
#(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int LEN_BITS    = LEN_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ch_valid,
    output logic        ch_stall,
    input  logic [7:0]  ch,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] token_pos,
    output logic [7:0]  token_len,
    output logic        last
);

    logic       full, push, pop, head_valid;
    kit_entry_t push_entry, head_entry;

    kit_front #(
        .POS_BITS (POS_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch_valid   (ch_valid),
        .ch         (ch),
        .full       (full),
        .ch_stall   (ch_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    kit_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    kit_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .token_kind (token_kind),
        .token_pos  (token_pos),
        .token_len  (token_len),
        .last       (last)
    );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the keyword/identifier tokenizer.
`timescale 1ns / 1ps

module testbench;
    import kit_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    // One expected token beat
    typedef struct {
        kit_kind_t  kind;
        logic [15:0] pos;
        logic [7:0]  len;
        logic        last;
    } token_beat_t;

    // Lexer predictor plus the store of tokens still due from the block
    class token_scoreboard;
        token_beat_t expected[$];
        token_beat_t fresh[$];
        int          errors;
        string       kw_word[KW_COUNT];
        logic [15:0] position;
        logic [15:0] tok_start;
        logic [7:0]  ident_len;
        bit          in_ident;
        bit          eq_pending;
        logic [6:0]  cands;

        function new();
            kw_word[0] = "fun";
            kw_word[1] = "forall";
            kw_word[2] = "Type";
            kw_word[3] = "Prop";
            kw_word[4] = "match";
            kw_word[5] = "with";
            kw_word[6] = "end";
            errors     = 0;
            position   = '0;
            tok_start  = '0;
            ident_len  = '0;
            in_ident   = 1'b0;
            eq_pending = 1'b0;
            cands      = '1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("tb: mismatch: %s", msg);
        endtask

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void push_tok(kit_kind_t k, logic [15:0] p, logic [7:0] l);
            token_beat_t t;
            t.kind = k;
            t.pos  = p;
            t.len  = l;
            t.last = 1'b0;
            fresh.push_back(t);
        endfunction

        // Keep only keywords whose character at idx is c
        function logic [6:0] narrow(logic [6:0] c0, logic [7:0] idx, logic [7:0] c);
            logic [6:0] r;
            int         i;
            r = c0;
            i = idx;
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (i >= kw_word[k].len())
                    r[k] = 1'b0;
                else if (kw_word[k][i] != c)
                    r[k] = 1'b0;
            end
            return r;
        endfunction

        function void close_ident();
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (cands[k] && int'(ident_len) == kw_word[k].len())
                begin
                    push_tok(kit_kind_t'(int'(KIND_KW_FUN) + k), tok_start,
                             8'(kw_word[k].len()));
                    in_ident = 1'b0;
                    return;
                end
            end
            push_tok(KIND_IDENT, tok_start, ident_len);
            in_ident = 1'b0;
        endfunction

        function void lex_step(logic [7:0] c);
            bit word_ch;
            word_ch = is_letter(c) || (c >= "0" && c <= "9");
            // a pending '=' is either an arrow or an error
            if (eq_pending)
            begin
                eq_pending = 1'b0;
                if (c == CH_GT)
                begin
                    push_tok(KIND_DARROW, tok_start, 8'd2);
                    position++;
                    return;
                end
                push_tok(KIND_ERROR, tok_start, 8'd1);
            end
            // an open identifier runs on over letters and digits
            if (in_ident)
            begin
                if (word_ch)
                begin
                    cands = narrow(cands, ident_len, c);
                    if (ident_len != 8'hFF)
                        ident_len++;
                    position++;
                    return;
                end
                close_ident();
            end
            case (c)
                CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
                CH_LPAREN: push_tok(KIND_LPAREN, position, 8'd1);
                CH_RPAREN: push_tok(KIND_RPAREN, position, 8'd1);
                CH_COLON:  push_tok(KIND_COLON, position, 8'd1);
                CH_COMMA:  push_tok(KIND_COMMA, position, 8'd1);
                CH_DOT:    push_tok(KIND_DOT, position, 8'd1);
                CH_PIPE:   push_tok(KIND_PIPE, position, 8'd1);
                CH_EQUALS:
                begin
                    eq_pending = 1'b1;
                    tok_start  = position;
                end
                CH_NUL:    push_tok(KIND_EOF, position, 8'd1);
                default:
                begin
                    if (is_letter(c) || c == CH_UNDER)
                    begin
                        in_ident  = 1'b1;
                        tok_start = position;
                        ident_len = 8'd1;
                        cands     = narrow(7'h7F, 8'd0, c);
                    end
                    else
                        push_tok(KIND_ERROR, position, 8'd1);
                end
            endcase
            position = (c == CH_NUL) ? 16'd0 : position + 16'd1;
        endfunction

        // Accepted input beat: queue the tokens it must cause
        function void note_char(logic [7:0] c);
            fresh.delete();
            lex_step(c);
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                expected.push_back(fresh[i]);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // Accepted output beat: compare with the oldest token due
        task check_token(logic [4:0] kind, logic [15:0] pos, logic [7:0] len, logic lst);
            token_beat_t w;
            if (expected.size() == 0)
            begin
                report($sformatf("unexpected token kind %0d pos %0d len %0d last %0b",
                                 kind, pos, len, lst));
                return;
            end
            w = expected.pop_front();
            if (kind !== w.kind || pos !== w.pos || len !== w.len || lst !== w.last)
                report($sformatf("got kind %0d pos %0d len %0d last %0b, want %0d %0d %0d %0b",
                                 kind, pos, len, lst, w.kind, w.pos, w.len, w.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        ch_valid;
    logic        ch_stall;
    logic [7:0]  ch;
    logic        tok_valid;
    logic        tok_stall;
    logic [4:0]  token_kind;
    logic [15:0] token_pos;
    logic [7:0]  token_len;
    logic        last;

    token_scoreboard ledger = new();
    bit calm;
    bit hold_req;
    bit holding;
    int lexemes_sent;

    keyword_identifier_tokenizer_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch_valid   (ch_valid),
        .ch_stall   (ch_stall),
        .ch         (ch),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .token_kind (token_kind),
        .token_pos  (token_pos),
        .token_len  (token_len),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] word_char(bit digits);
        int r;
        r = $urandom_range(0, digits ? 2 : 1);
        if (r == 0)
            return 8'("a" + $urandom_range(0, 25));
        if (r == 1)
            return 8'("A" + $urandom_range(0, 25));
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Offer one byte and wait for its beat; called at a rising edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            ch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ch_valid <= 1'b1;
        ch       <= b;
        @(posedge clk);
        while (ch_stall)
            @(posedge clk);
        ledger.note_char(b);
        if (b != CH_SPACE && b != CH_TAB && b != CH_CR && b != CH_LF)
            lexemes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Stop offering and wait until every token due has come out
    task automatic drain();
        ch_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_long_ident(input int n);
        send_byte(word_char(1'b0));
        repeat (n - 1) send_byte(word_char(1'b1));
        send_byte(CH_SPACE);
    endtask

    // One random lexeme, mostly well formed, sometimes noise
    task automatic send_piece();
        int    r;
        int    n;
        string w;
        r = $urandom_range(0, 99);
        if (r < 22)
        begin
            w = ledger.kw_word[$urandom_range(0, KW_COUNT - 1)];
            n = $urandom_range(0, 9);
            if (n == 0)
                w = w.substr(0, w.len() - 2);
            send_str(w);
            if (n == 1)
                send_byte(word_char(1'b1));
        end
        else if (r < 40)
        begin
            send_byte(($urandom_range(0, 9) == 0) ? CH_UNDER : word_char(1'b0));
            repeat ($urandom_range(0, 7))
                send_byte(($urandom_range(0, 15) == 0) ? CH_UNDER : word_char(1'b1));
        end
        else if (r < 58)
        begin
            case ($urandom_range(0, 6))
                0:       send_byte(CH_LPAREN);
                1:       send_byte(CH_RPAREN);
                2:       send_byte(CH_COLON);
                3:       send_byte(CH_COMMA);
                4:       send_byte(CH_DOT);
                5:       send_byte(CH_PIPE);
                default: send_str("=>");
            endcase
        end
        else if (r < 72)
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 3))
                    0:       send_byte(CH_SPACE);
                    1:       send_byte(CH_TAB);
                    2:       send_byte(CH_CR);
                    default: send_byte(CH_LF);
                endcase
            end
        end
        else if (r < 80)
            send_byte(CH_EQUALS);
        else if (r < 96)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_byte(CH_NUL);
    endtask

    // Token receiver: random stalls, one long hold on request
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                holding  = 1'b1;
                tok_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end
            else
            begin
                n = idle_len();
                if (n > 0)
                begin
                    tok_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            tok_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && tok_valid && !tok_stall)
            ledger.check_token(token_kind, token_pos, token_len, last);
    end

    // Watchdog on cycles with no beat on either side
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((ch_valid && !ch_stall) || (tok_valid && !tok_stall))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus
    initial
    begin
        bit held;
        bit paused;
        int long_done;
        calm         = 1'b0;
        hold_req     = 1'b0;
        holding      = 1'b0;
        lexemes_sent = 0;
        held         = 1'b0;
        paused       = 1'b0;
        long_done    = 0;
        rst_n     <= 1'b0;
        ch_valid  <= 1'b0;
        ch        <= 8'h00;
        tok_stall <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every punctuation, arrow, lone equals, bytes above 127,
        // whitespace kinds, eof with pending '=' and with an open identifier
        send_str("fun(x1):=>y,=.|");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(CH_TAB);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_EQUALS);
        send_byte(CH_NUL);
        send_str("a_");
        send_byte(CH_NUL);
        drain();

        // random lexemes with the pressure phases folded in
        lexemes_sent = 0;
        while (lexemes_sent < 2000)
        begin
            if (!held && lexemes_sent > 400)
            begin
                // long output hold while the sender keeps pushing
                held     = 1'b1;
                hold_req = 1'b1;
                ch_valid <= 1'b0;
                @(posedge clk);
                while (!holding)
                    @(posedge clk);
                calm = 1'b1;
                repeat (12) send_str("(x):");
                calm = 1'b0;
            end
            if (!paused && lexemes_sent > 800)
            begin
                paused = 1'b1;
                drain();
            end
            if (long_done == 0 && lexemes_sent > 1000)
            begin
                long_done = 1;
                send_long_ident(255);
            end
            if (long_done == 1 && lexemes_sent > 1600)
            begin
                long_done = 2;
                send_long_ident(300);
            end
            calm = (lexemes_sent > 1300 && lexemes_sent < 1500);
            send_piece();
        end
        calm = 1'b0;

        // close with an identifier, an arrow and end of file
        send_str("abcdef(x=>y");
        send_byte(CH_NUL);

        drain();
        repeat (20) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
design/kit_pkg.sv
design/kit_front.sv
design/kit_queue.sv
design/kit_back.sv
design/keyword_identifier_tokenizer_top.sv
tb/sv/testbench.sv
